// ===== sv/sha256_message_digest_core_macros.svh =====
// Assertion macros shared by the SHA-256 digest core.
// Included by the files that carry concurrent assertions.
`ifndef SHA256_MESSAGE_DIGEST_CORE_MACROS_SVH
`define SHA256_MESSAGE_DIGEST_CORE_MACROS_SVH
// Implication checked on every rising clock edge outside reset.
`define SHA_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// Next-cycle implication checked outside reset.
`define SHA_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`endif

// ===== sv/sha_pkg.sv =====
// Package for the SHA-256 digest core: constants, round table, a rotate function,
// channel payloads and the controller/datapath command and status structs.
package sha_pkg;

  localparam logic [31:0] RoundK [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
    32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
    32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
    32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
    32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
    32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam logic [31:0] InitHash [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [7:0] PadByte = 8'h80;
  localparam logic [5:0] LenOffset = 6'd56;

  // Payload of one input word and of one digest word.
  typedef struct packed {
    logic [7:0] data_byte;
    logic       byte_present;
    logic       end_of_message;
  } msg_word_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
  } digest_word_t;

  // Byte source selected by the controller for a store write.
  typedef enum logic [1:0] {
    SRC_DATA = 2'd0,
    SRC_PAD  = 2'd1,
    SRC_ZERO = 2'd2,
    SRC_LEN  = 2'd3
  } byte_src_t;

  typedef struct packed {
    logic      put;        // write one byte and advance fill position
    byte_src_t src;
    logic      count;      // add eight to the bit count
    logic      latch_len;  // capture bit count for the length field
    logic      load;       // start a compression: load working vars
    logic      round;      // perform one round
    logic      fold;       // add working vars into chain value
    logic      restart;    // return to initial values
    logic      shift_out;  // rotate chain value for digest output
  } sha_cmd_t;

  typedef struct packed {
    logic [5:0] fill;
    logic [5:0] rnd;
  } sha_status_t;

  function automatic logic [31:0] rotr(input logic [31:0] v, input int s);
    rotr = (v >> s) | (v << (32 - s));
  endfunction

endpackage

// ===== sv/sha_stream_if.sv =====
// Valid/ready channel interface carrying a generic payload.
// Depends on nothing; the payload type is set per instance.
interface sha_stream_if #(parameter type payload_t = logic) (input logic clk);
  logic     valid;
  logic     ready;
  payload_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== sv/sha256_message_digest_core.sv =====
// SHA-256 digest core top level: joins the controller and the datapath
// behind two valid/ready channels. Uses sha_pkg, sha_stream_if, sha_ctrl, sha_datapath.
// A word without end mark needs no further step; the 64th byte of a block adds
// a compression (load, 64 rounds of the single round unit, fold).
// An end word adds padding and length writes plus one or two
// compressions, then eight digest words, one per accepted output cycle.
// Reset (synchronous, active high) restores the initial hash and a zero count.
module sha256_message_digest_core (
  input logic clk,
  input logic rst,
  sha_stream_if.sink   in_ch,
  sha_stream_if.source out_ch
);
  import sha_pkg::*;

  sha_cmd_t    cmd;
  sha_status_t status;
  logic [31:0] head_word;
  logic [2:0]  out_index;

  // The controller sequences every byte write, round and output word.
  sha_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_ch.valid),
    .in_ready   (in_ch.ready),
    .in_present (in_ch.data.byte_present),
    .in_end     (in_ch.data.end_of_message),
    .out_valid  (out_ch.valid),
    .out_ready  (out_ch.ready),
    .out_index  (out_index),
    .status     (status),
    .cmd        (cmd)
  );

  // The datapath holds the block, the schedule and the chaining value.
  sha_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .data_byte (in_ch.data.data_byte),
    .status    (status),
    .head_word (head_word)
  );

  // The chaining value rotates so its head is always the word being shown.
  assign out_ch.data.digest_word = head_word;
  assign out_ch.data.word_index = out_index;
  assign out_ch.data.last_word = (out_index == 3'd7);
endmodule

// ===== sv/sha_datapath.sv =====
// Datapath of the SHA-256 core: schedule window (which also collects the block
// bytes), round logic, chaining value and bit count. Uses sha_pkg, driven by sha_ctrl.
module sha_datapath (
  input  logic                 clk,
  input  logic                 rst,
  input  sha_pkg::sha_cmd_t    cmd,
  input  logic [7:0]           data_byte,
  output sha_pkg::sha_status_t status,
  output logic [31:0]          head_word
);
  import sha_pkg::*;

  logic [31:0] sched [16];
  logic [31:0] chain [8];
  logic [31:0] v [8];
  logic [63:0] message_bits;
  logic [63:0] len;
  logic [5:0]  fill;
  logic [5:0]  rnd;
  logic [7:0]  put_val;
  logic [4:0]  lane;
  logic [31:0] w, t1, t2, s0, s1, e, a;

  always_comb begin
    case (cmd.src)
      SRC_DATA: put_val = data_byte;
      SRC_PAD:  put_val = PadByte;
      SRC_ZERO: put_val = 8'h00;
      SRC_LEN:  put_val = len[63:56];
      default:  put_val = 8'h00;
    endcase
  end

  // Bytes land big-endian in the window word picked by the upper fill bits.
  assign lane = {~fill[1:0], 3'b000};

  // The window is shifted each round: sched[0] is the current word for rounds 0 to 15, later w is built from it.
  always_comb begin
    s0 = rotr(sched[1], 7) ^ rotr(sched[1], 18) ^ (sched[1] >> 3);
    s1 = rotr(sched[14], 17) ^ rotr(sched[14], 19) ^ (sched[14] >> 10);
    w  = (rnd < 6'd16) ? sched[0] : s1 + sched[9] + s0 + sched[0];
    e  = v[4];
    a  = v[0];
    t1 = v[7] + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25)) + ((e & v[5]) ^ (~e & v[6]))
         + RoundK[rnd] + w;
    t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22)) + ((a & v[1]) ^ (a & v[2]) ^ (v[1] & v[2]));
  end

  always_ff @(posedge clk) begin
    if (cmd.put) begin
      sched[fill[5:2]][lane +: 8] <= put_val;
    end
    if (cmd.latch_len) begin
      len <= message_bits;
    end else if (cmd.put && cmd.src == SRC_LEN) begin
      len <= {len[55:0], 8'h00};
    end
    if (cmd.load) begin
      for (int i = 0; i < 8; i++) begin
        v[i] <= chain[i];
      end
    end else if (cmd.round) begin
      for (int i = 0; i < 15; i++) begin
        sched[i] <= sched[i+1];
      end
      sched[15] <= w;
      v[7] <= v[6]; v[6] <= v[5]; v[5] <= v[4]; v[4] <= v[3] + t1;
      v[3] <= v[2]; v[2] <= v[1]; v[1] <= v[0]; v[0] <= t1 + t2;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.restart) begin
      for (int i = 0; i < 8; i++) begin
        chain[i] <= InitHash[i];
      end
      message_bits <= '0;
      fill <= '0;
      rnd <= '0;
    end else begin
      if (cmd.put) begin
        fill <= fill + 6'd1;
      end
      if (cmd.count) begin
        message_bits <= message_bits + 64'd8;
      end
      if (cmd.load) begin
        rnd <= '0;
      end else if (cmd.round) begin
        rnd <= rnd + 6'd1;
      end
      if (cmd.fold) begin
        for (int i = 0; i < 8; i++) begin
          chain[i] <= chain[i] + v[i];
        end
      end else if (cmd.shift_out) begin
        for (int i = 0; i < 7; i++) begin
          chain[i] <= chain[i+1];
        end
        chain[7] <= chain[0];
      end
    end
  end

  assign status.fill = fill;
  assign status.rnd = rnd;
  assign head_word = chain[0];
endmodule

// ===== sv/sha_ctrl.sv =====
// Controller state machine of the SHA-256 core: input handshake, padding
// sequence, round sequencing and digest output. Uses sha_pkg and the macros.
`include "sha256_message_digest_core_macros.svh"
module sha_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 in_present,
  input  logic                 in_end,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [2:0]           out_index,
  input  sha_pkg::sha_status_t status,
  output sha_pkg::sha_cmd_t    cmd
);
  import sha_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE, ST_PAD, ST_ZERO, ST_LEN, ST_LOAD, ST_ROUND, ST_FOLD, ST_OUT
  } state_t;

  state_t     state;
  logic       padding;   // compression belongs to the final padding
  logic       pend_end;  // end mark waits after a data-byte compression
  logic [2:0] len_cnt;
  logic       acc;

  assign in_ready = (state == ST_IDLE);
  assign acc = in_valid && in_ready;
  assign out_valid = (state == ST_OUT);

  always_comb begin
    cmd = '0;
    case (state)
      ST_IDLE: begin
        cmd.put = acc && in_present;
        cmd.count = acc && in_present;
        cmd.src = SRC_DATA;
      end
      ST_PAD: begin
        cmd.put = 1'b1; cmd.src = SRC_PAD; cmd.latch_len = 1'b1;
      end
      ST_ZERO: begin
        cmd.put = (status.fill != LenOffset);
        cmd.src = SRC_ZERO;
      end
      ST_LEN:   begin cmd.put = 1'b1; cmd.src = SRC_LEN; end
      ST_LOAD:  cmd.load = 1'b1;
      ST_ROUND: cmd.round = 1'b1;
      ST_FOLD:  cmd.fold = 1'b1;
      ST_OUT: begin
        cmd.shift_out = out_ready;
        cmd.restart = out_ready && (out_index == 3'd7);
      end
      default: cmd = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      padding <= 1'b0;
      pend_end <= 1'b0;
      len_cnt <= '0;
      out_index <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (acc) begin
            if (in_present && status.fill == 6'd63) begin
              state <= ST_LOAD; padding <= 1'b0; pend_end <= in_end;
            end else if (in_end) begin
              state <= ST_PAD;
            end
          end
        end
        ST_PAD: begin
          padding <= 1'b1;
          state <= (status.fill == 6'd63) ? ST_LOAD : ST_ZERO;
        end
        ST_ZERO: begin
          if (status.fill == LenOffset) begin
            state <= ST_LEN; len_cnt <= '0;
          end else if (status.fill == 6'd63) begin
            state <= ST_LOAD;
          end
        end
        ST_LEN: begin
          if (len_cnt == 3'd7) begin
            state <= ST_LOAD;
          end else begin
            len_cnt <= len_cnt + 3'd1;
          end
        end
        ST_LOAD: state <= ST_ROUND;
        ST_ROUND: begin
          if (status.rnd == 6'd63) begin
            state <= ST_FOLD;
          end
        end
        ST_FOLD: begin
          if (pend_end) begin
            pend_end <= 1'b0; state <= ST_PAD;
          end else if (padding && status.fill == 6'd0 && len_cnt == 3'd0) begin
            state <= ST_ZERO;
          end else if (padding) begin
            state <= ST_OUT; out_index <= '0; padding <= 1'b0; len_cnt <= '0;
          end else begin
            state <= ST_IDLE;
          end
        end
        ST_OUT: begin
          if (out_ready) begin
            out_index <= out_index + 3'd1;
            if (out_index == 3'd7) begin
              state <= ST_IDLE;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  `SHA_ASSERT_IMP(a_no_put_in_rounds, clk, rst, state == ST_ROUND, !cmd.put, "byte write during rounds")
  `SHA_ASSERT_NXT(a_round_to_fold, clk, rst, state == ST_ROUND && status.rnd == 6'd63, state == ST_FOLD, "round count overrun")
  `SHA_ASSERT_IMP(a_len_at_56, clk, rst, state == ST_LEN && len_cnt == 3'd0, status.fill == LenOffset, "length not at offset 56")
  `SHA_ASSERT_IMP(a_out_not_ready, clk, rst, out_valid, !in_ready, "input taken while digest out")
endmodule
